[design/sctd_pkg.sv]
// Shared constants, types and the month table for the seconds-to-calendar converter.
// No dependencies; every other file in design/ imports this package.
package sctd_pkg;

  // Seconds per day is 2^7 * 675; the quotient comes from (ts >> 7) * DAY_RECIP >> DAY_SHIFT.
  localparam int unsigned DAY_SHIFT = 35;
  localparam logic [25:0] DAY_RECIP = 26'd50903317;
  localparam logic [16:0] SECS_PER_DAY = 17'd86400;

  // Year is (4 * day) * YEAR_RECIP >> YEAR_SHIFT, i.e. floor(4 * day / 1461).
  localparam int unsigned YEAR_SHIFT = 29;
  localparam logic [18:0] YEAR_RECIP = 19'd367469;
  localparam logic [18:0] DAYS_PER_4Y = 19'd1461;
  localparam logic [7:0] YEAR_LIMIT = 8'd100;
  localparam logic [6:0] YEAR_CLAMP = 7'd99;
  localparam logic [3:0] MONTH_CLAMP = 4'd12;
  localparam logic [4:0] MDAY_CLAMP = 5'd31;

  // Hour is (sod >> 4) * HOUR_RECIP >> HOUR_SHIFT, since 3600 = 2^4 * 225.
  localparam int unsigned HOUR_SHIFT = 21;
  localparam logic [13:0] HOUR_RECIP = 14'd9321;
  localparam logic [11:0] SECS_PER_HOUR = 12'd3600;

  // Minute is (rem >> 2) * MIN_RECIP >> MIN_SHIFT, since 60 = 2^2 * 15.
  localparam int unsigned MIN_SHIFT = 14;
  localparam logic [10:0] MIN_RECIP = 11'd1093;
  localparam logic [11:0] SECS_PER_MIN = 12'd60;

  localparam int unsigned NUM_STAGES = 6;
  localparam int unsigned MONTH_STEPS = 11;

  typedef logic [31:0] ts_t;
  typedef logic [15:0] day_t;
  typedef logic [16:0] sod_t;
  typedef logic [8:0] doy_t;

  // Last day of the year (1-based) that falls in month idx (0 is January).
  function automatic doy_t month_end(input logic leap, input logic [3:0] idx);
    doy_t base;
    case (idx)
      4'd0:    base = 9'd31;
      4'd1:    base = 9'd59;
      4'd2:    base = 9'd90;
      4'd3:    base = 9'd120;
      4'd4:    base = 9'd151;
      4'd5:    base = 9'd181;
      4'd6:    base = 9'd212;
      4'd7:    base = 9'd243;
      4'd8:    base = 9'd273;
      4'd9:    base = 9'd304;
      4'd10:   base = 9'd334;
      default: base = 9'd365;
    endcase
    if (leap && idx != 4'd0) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

endpackage

[design/sctd_day_split.sv]
// Stages 1 and 2: split the timestamp into day number and seconds since midnight.
// Depends on sctd_pkg.
module sctd_day_split
  import sctd_pkg::*;
(
  input  logic clk,
  input  logic adv,
  input  ts_t  ts,
  output day_t day,
  output sod_t sod
);

  logic [50:0] prod_r;
  ts_t         ts_r;
  day_t        day_r;
  sod_t        sod_r;

  logic [32:0] day_secs;
  day_t        day_nxt;
  sod_t        sod_nxt;

  assign day_nxt  = prod_r[DAY_SHIFT +: 16];
  assign day_secs = {17'd0, day_nxt} * {16'd0, SECS_PER_DAY};
  assign sod_nxt  = sod_t'(ts_r - day_secs[31:0]);

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= {26'd0, ts[31:7]} * {25'd0, DAY_RECIP};
      ts_r   <= ts;
      day_r  <= day_nxt;
      sod_r  <= sod_nxt;
    end
  end

  assign day = day_r;
  assign sod = sod_r;

endmodule

[design/sctd_time.sv]
// Stages 3 to 6: hour, minute and second from the seconds since midnight.
// Depends on sctd_pkg.
module sctd_time
  import sctd_pkg::*;
(
  input  logic       clk,
  input  logic       adv,
  input  sod_t       sod,
  output logic [4:0] hour,
  output logic [5:0] minute,
  output logic [5:0] second
);

  logic [26:0] hprod_r;
  sod_t        sod3_r;
  logic [4:0]  hour4_r;
  logic [11:0] rem4_r;
  logic [20:0] mprod_r;
  logic [4:0]  hour5_r;
  logic [11:0] rem5_r;
  logic [4:0]  hour6_r;
  logic [5:0]  min6_r;
  logic [5:0]  sec6_r;

  logic [4:0]  hour4_nxt;
  logic [16:0] hour_secs;
  logic [11:0] rem4_nxt;
  logic [5:0]  min6_nxt;
  logic [11:0] min_secs;

  // Drop the four low bits: 3600 carries a factor of 16.
  function automatic logic [12:0] sod3_nxt_shift(input sod_t s);
    return s[16:4];
  endfunction

  assign hour4_nxt = hprod_r[HOUR_SHIFT +: 5];
  assign hour_secs = {12'd0, hour4_nxt} * {5'd0, SECS_PER_HOUR};
  assign rem4_nxt  = 12'(sod3_r - hour_secs);
  assign min6_nxt  = mprod_r[MIN_SHIFT +: 6];
  assign min_secs  = {6'd0, min6_nxt} * SECS_PER_MIN;

  always_ff @(posedge clk) begin
    if (adv) begin
      hprod_r <= {14'd0, sod3_nxt_shift(sod)} * {13'd0, HOUR_RECIP};
      sod3_r  <= sod;
      hour4_r <= hour4_nxt;
      rem4_r  <= rem4_nxt;
      mprod_r <= {11'd0, rem4_r[11:2]} * {10'd0, MIN_RECIP};
      hour5_r <= hour4_r;
      rem5_r  <= rem4_r;
      hour6_r <= hour5_r;
      min6_r  <= min6_nxt;
      sec6_r  <= 6'(rem5_r - min_secs);
    end
  end

  assign hour   = hour6_r;
  assign minute = min6_r;
  assign second = sec6_r;

endmodule

[design/sctd_date.sv]
// Stages 3 to 6: year, month and day of month from the day number, with saturation.
// Depends on sctd_pkg (reciprocal constants and the month_end table).
module sctd_date
  import sctd_pkg::*;
(
  input  logic       clk,
  input  logic       adv,
  input  day_t       day,
  output logic [6:0] year,
  output logic [3:0] month,
  output logic [4:0] mday,
  output logic       sat
);

  logic [36:0] yprod_r;
  day_t        day3_r;
  logic [7:0]  year4_r;
  doy_t        doy4_r;
  logic        leap4_r;
  logic        sat4_r;
  logic [6:0]  year5_r;
  logic [3:0]  month5_r;
  logic [4:0]  mday5_r;
  logic        sat5_r;
  logic [6:0]  year6_r;
  logic [3:0]  month6_r;
  logic [4:0]  mday6_r;
  logic        sat6_r;

  logic [7:0]  year4_nxt;
  logic [18:0] ystart_x4;
  logic [16:0] ystart;
  logic [16:0] doy_full;
  logic [MONTH_STEPS-1:0] past_end;
  doy_t        mstart;
  logic [3:0]  mcount;
  doy_t        mday_full;

  assign year4_nxt = yprod_r[YEAR_SHIFT +: 8];
  assign ystart_x4 = {11'd0, year4_nxt} * DAYS_PER_4Y + 19'd3;
  assign ystart    = ystart_x4[18:2];
  assign doy_full  = {1'b0, day3_r} + 17'd1 - ystart;

  // Month walk as parallel compares against the cumulative month ends.
  always_comb begin
    mstart = '0;
    mcount = '0;
    for (int i = 0; i < MONTH_STEPS; i++) begin
      past_end[i] = doy4_r > month_end(leap4_r, 4'(i));
      if (past_end[i]) begin
        mstart = month_end(leap4_r, 4'(i));
      end
      mcount = mcount + {3'd0, past_end[i]};
    end
  end

  assign mday_full = doy4_r - mstart;

  always_ff @(posedge clk) begin
    if (adv) begin
      yprod_r  <= {19'd0, day, 2'b00} * {18'd0, YEAR_RECIP};
      day3_r   <= day;
      year4_r  <= year4_nxt;
      doy4_r   <= doy_full[8:0];
      leap4_r  <= year4_nxt[1:0] == 2'b00;
      sat4_r   <= year4_nxt >= YEAR_LIMIT;
      year5_r  <= year4_r[6:0];
      month5_r <= mcount + 4'd1;
      mday5_r  <= mday_full[4:0];
      sat5_r   <= sat4_r;
      // Clamp the date once the century runs out.
      year6_r  <= sat5_r ? YEAR_CLAMP : year5_r;
      month6_r <= sat5_r ? MONTH_CLAMP : month5_r;
      mday6_r  <= sat5_r ? MDAY_CLAMP : mday5_r;
      sat6_r   <= sat5_r;
    end
  end

  assign year  = year6_r;
  assign month = month6_r;
  assign mday  = mday6_r;
  assign sat   = sat6_r;

endmodule

[design/seconds_to_calendar_date_time.sv]
// Top level of the seconds-to-calendar converter: valid bits, stall and the two datapaths.
// Depends on sctd_pkg, sctd_day_split, sctd_time and sctd_date.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_stall  | in_timestamp_seconds
//   out     | output    | out_valid / out_stall| date and time fields, date_saturated
//
// Six register stages; one beat enters per cycle while the output is not stalled.
// The depth is set by the chain of reciprocal multiplies: day, then hour, then minute.
// A stalled result holds the whole pipeline, and in_stall follows at once.
// Bubbles do not hold anything back: only a valid beat at the output can stall.
// rst_n clears the valid bits only; the datapath registers carry no reset.
module seconds_to_calendar_date_time
  import sctd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  ts_t        in_timestamp_seconds,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] out_year_of_century,
  output logic [3:0] out_month_number,
  output logic [4:0] out_day_of_month,
  output logic [4:0] out_hour_of_day,
  output logic [5:0] out_minute_of_hour,
  output logic [5:0] out_second_of_minute,
  output logic       out_date_saturated
);

  logic [NUM_STAGES-1:0] valid_r;
  logic [NUM_STAGES-1:0] valid_nxt;
  logic                  adv;
  day_t                  day;
  sod_t                  sod;

  // Advance unless a finished beat is held at the output.
  assign adv       = !(valid_r[NUM_STAGES-1] && out_stall);
  assign in_stall  = !adv;
  assign valid_nxt = {valid_r[NUM_STAGES-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (adv) begin
      valid_r <= valid_nxt;
    end
  end

  sctd_day_split u_split (
    .clk (clk),
    .adv (adv),
    .ts  (in_timestamp_seconds),
    .day (day),
    .sod (sod)
  );

  sctd_time u_time (
    .clk    (clk),
    .adv    (adv),
    .sod    (sod),
    .hour   (out_hour_of_day),
    .minute (out_minute_of_hour),
    .second (out_second_of_minute)
  );

  sctd_date u_date (
    .clk   (clk),
    .adv   (adv),
    .day   (day),
    .year  (out_year_of_century),
    .month (out_month_number),
    .mday  (out_day_of_month),
    .sat   (out_date_saturated)
  );

  assign out_valid = valid_r[NUM_STAGES-1];

  a_clamped_date: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_date_saturated |->
      out_year_of_century == YEAR_CLAMP && out_month_number == MONTH_CLAMP &&
      out_day_of_month == MDAY_CLAMP)
    else $error("saturated beat carries an unclamped date");

  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      out_hour_of_day <= 5'd23 && out_minute_of_hour <= 6'd59 &&
      out_second_of_minute <= 6'd59)
    else $error("time of day out of range");

  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_date_saturated |->
      out_year_of_century < 7'd100 && out_month_number >= 4'd1 &&
      out_month_number <= 4'd12 && out_day_of_month >= 5'd1)
    else $error("date out of range");

  a_stall_holds_beat: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[0] && in_stall |=> valid_r[0])
    else $error("stalled pipeline lost a beat");

endmodule
